FILE: design/sha512_pkg.sv
// Shared types, constants and round functions for the SHA-512 hash core.
// No dependencies; every other design file refers to this package by scope.
package sha512_pkg;

    localparam int WORD_W      = 64;
    localparam int HASH_WORDS  = 8;
    localparam int CHUNK_WORDS = 16;
    localparam int ROUNDS      = 80;
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int CNT_W       = $clog2(CHUNK_WORDS);
    localparam int OIDX_W      = $clog2(HASH_WORDS);

    localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(ROUNDS - 1);
    localparam logic [CNT_W-1:0]   LAST_SLOT   = CNT_W'(CHUNK_WORDS - 1);
    localparam logic [OIDX_W-1:0]  LAST_DIGEST = OIDX_W'(HASH_WORDS - 1);

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [HASH_WORDS-1:0] t_hash;

    typedef struct packed {
        t_word message_word;
        logic  start_message;
        logic  last_word;
    } t_in;

    typedef struct packed {
        t_word digest_word;
        logic  final_word;
        logic  length_error;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMP,
        S_ADD,
        S_OUT,
        S_ERR
    } t_state;

    typedef struct packed {
        logic word_en;
        logic round_en;
    } t_sched_ctl;

    typedef struct packed {
        logic                init;
        logic                step;
        logic [ROUND_W-1:0]  idx;
    } t_round_ctl;

    // Element 0 is H0.
    localparam t_hash INIT_HASH = {
        64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
        64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
        64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
        64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic t_word round_k(input logic [ROUND_W-1:0] idx);
        unique case (idx)
            7'd0:  round_k = 64'h428a2f98d728ae22;
            7'd1:  round_k = 64'h7137449123ef65cd;
            7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  round_k = 64'he9b5dba58189dbbc;
            7'd4:  round_k = 64'h3956c25bf348b538;
            7'd5:  round_k = 64'h59f111f1b605d019;
            7'd6:  round_k = 64'h923f82a4af194f9b;
            7'd7:  round_k = 64'hab1c5ed5da6d8118;
            7'd8:  round_k = 64'hd807aa98a3030242;
            7'd9:  round_k = 64'h12835b0145706fbe;
            7'd10: round_k = 64'h243185be4ee4b28c;
            7'd11: round_k = 64'h550c7dc3d5ffb4e2;
            7'd12: round_k = 64'h72be5d74f27b896f;
            7'd13: round_k = 64'h80deb1fe3b1696b1;
            7'd14: round_k = 64'h9bdc06a725c71235;
            7'd15: round_k = 64'hc19bf174cf692694;
            7'd16: round_k = 64'he49b69c19ef14ad2;
            7'd17: round_k = 64'hefbe4786384f25e3;
            7'd18: round_k = 64'h0fc19dc68b8cd5b5;
            7'd19: round_k = 64'h240ca1cc77ac9c65;
            7'd20: round_k = 64'h2de92c6f592b0275;
            7'd21: round_k = 64'h4a7484aa6ea6e483;
            7'd22: round_k = 64'h5cb0a9dcbd41fbd4;
            7'd23: round_k = 64'h76f988da831153b5;
            7'd24: round_k = 64'h983e5152ee66dfab;
            7'd25: round_k = 64'ha831c66d2db43210;
            7'd26: round_k = 64'hb00327c898fb213f;
            7'd27: round_k = 64'hbf597fc7beef0ee4;
            7'd28: round_k = 64'hc6e00bf33da88fc2;
            7'd29: round_k = 64'hd5a79147930aa725;
            7'd30: round_k = 64'h06ca6351e003826f;
            7'd31: round_k = 64'h142929670a0e6e70;
            7'd32: round_k = 64'h27b70a8546d22ffc;
            7'd33: round_k = 64'h2e1b21385c26c926;
            7'd34: round_k = 64'h4d2c6dfc5ac42aed;
            7'd35: round_k = 64'h53380d139d95b3df;
            7'd36: round_k = 64'h650a73548baf63de;
            7'd37: round_k = 64'h766a0abb3c77b2a8;
            7'd38: round_k = 64'h81c2c92e47edaee6;
            7'd39: round_k = 64'h92722c851482353b;
            7'd40: round_k = 64'ha2bfe8a14cf10364;
            7'd41: round_k = 64'ha81a664bbc423001;
            7'd42: round_k = 64'hc24b8b70d0f89791;
            7'd43: round_k = 64'hc76c51a30654be30;
            7'd44: round_k = 64'hd192e819d6ef5218;
            7'd45: round_k = 64'hd69906245565a910;
            7'd46: round_k = 64'hf40e35855771202a;
            7'd47: round_k = 64'h106aa07032bbd1b8;
            7'd48: round_k = 64'h19a4c116b8d2d0c8;
            7'd49: round_k = 64'h1e376c085141ab53;
            7'd50: round_k = 64'h2748774cdf8eeb99;
            7'd51: round_k = 64'h34b0bcb5e19b48a8;
            7'd52: round_k = 64'h391c0cb3c5c95a63;
            7'd53: round_k = 64'h4ed8aa4ae3418acb;
            7'd54: round_k = 64'h5b9cca4f7763e373;
            7'd55: round_k = 64'h682e6ff3d6b2b8a3;
            7'd56: round_k = 64'h748f82ee5defb2fc;
            7'd57: round_k = 64'h78a5636f43172f60;
            7'd58: round_k = 64'h84c87814a1f0ab72;
            7'd59: round_k = 64'h8cc702081a6439ec;
            7'd60: round_k = 64'h90befffa23631e28;
            7'd61: round_k = 64'ha4506cebde82bde9;
            7'd62: round_k = 64'hbef9a3f7b2c67915;
            7'd63: round_k = 64'hc67178f2e372532b;
            7'd64: round_k = 64'hca273eceea26619c;
            7'd65: round_k = 64'hd186b8c721c0c207;
            7'd66: round_k = 64'heada7dd6cde0eb1e;
            7'd67: round_k = 64'hf57d4f7fee6ed178;
            7'd68: round_k = 64'h06f067aa72176fba;
            7'd69: round_k = 64'h0a637dc5a2c898a6;
            7'd70: round_k = 64'h113f9804bef90dae;
            7'd71: round_k = 64'h1b710b35131c471b;
            7'd72: round_k = 64'h28db77f523047d84;
            7'd73: round_k = 64'h32caab7b40c72493;
            7'd74: round_k = 64'h3c9ebe0a15c9bebc;
            7'd75: round_k = 64'h431d67c49c100d4c;
            7'd76: round_k = 64'h4cc5d4becb3e42b6;
            7'd77: round_k = 64'h597f299cfc657e2a;
            7'd78: round_k = 64'h5fcb6fab3ad6faec;
            7'd79: round_k = 64'h6c44198c4a475817;
            default: round_k = '0;
        endcase
    endfunction

endpackage

FILE: design/sha512_hash_core.sv
// Top level of the SHA-512 hash core: sequencer, hash state and result port.
// Depends on sha512_pkg, sha512_sched and sha512_round.
//
//   Channel  | Direction | Handshake              | Beat payload (sha512_pkg)
//   ---------+-----------+------------------------+---------------------------------
//   input    | in        | i_in_valid, o_in_stall | t_in: message_word, start, last
//   result   | out       | o_out_valid, i_out_stall | t_out: digest_word, final, error
//
// A word that does not close a 1024-bit chunk is shifted straight into the schedule.
// The word that closes a chunk starts the compression: all 80 rounds run through the
// single shared round unit, then the S_ADD state folds the result into the hash.
// Input is stalled for the whole compression and while results are pending. Reset
// is synchronous and active low; it loads the standard initial hash and clears the
// word count. A result beat stays put while stalled.
module sha512_hash_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sha512_pkg::t_in  i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sha512_pkg::t_out o_out_data
);

    sha512_pkg::t_state r_state;
    sha512_pkg::t_state n_state;

    logic [sha512_pkg::CNT_W-1:0]   r_cnt;
    logic [sha512_pkg::CNT_W-1:0]   n_cnt;
    logic [sha512_pkg::ROUND_W-1:0] r_rnd;
    logic [sha512_pkg::ROUND_W-1:0] n_rnd;
    logic [sha512_pkg::OIDX_W-1:0]  r_oidx;
    logic [sha512_pkg::OIDX_W-1:0]  n_oidx;
    logic                           r_last;
    logic                           n_last;
    sha512_pkg::t_hash              r_hash;
    sha512_pkg::t_hash              n_hash;

    logic                           in_acc;
    logic                           out_acc;
    logic [sha512_pkg::CNT_W-1:0]   eff_cnt;
    logic                           chunk_done;

    sha512_pkg::t_sched_ctl         sched_ctl;
    sha512_pkg::t_round_ctl         round_ctl;
    sha512_pkg::t_word              sched_w;
    sha512_pkg::t_hash              vars;

    // A start flag clears the word count before its own word lands.
    always_comb begin
        eff_cnt    = i_in_data.start_message ? '0 : r_cnt;
        chunk_done = (eff_cnt == sha512_pkg::LAST_SLOT);
        in_acc     = i_in_valid && !o_in_stall;
        out_acc    = o_out_valid && !i_out_stall;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha512_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (chunk_done) begin
                        n_state = sha512_pkg::S_COMP;
                    end else if (i_in_data.last_word) begin
                        n_state = sha512_pkg::S_ERR;
                    end
                end
            end
            sha512_pkg::S_COMP: begin
                if (r_rnd == sha512_pkg::LAST_ROUND) begin
                    n_state = sha512_pkg::S_ADD;
                end
            end
            sha512_pkg::S_ADD: begin
                n_state = r_last ? sha512_pkg::S_OUT : sha512_pkg::S_IDLE;
            end
            sha512_pkg::S_OUT: begin
                if (out_acc && r_oidx == sha512_pkg::LAST_DIGEST) begin
                    n_state = sha512_pkg::S_IDLE;
                end
            end
            sha512_pkg::S_ERR: begin
                if (out_acc) begin
                    n_state = sha512_pkg::S_IDLE;
                end
            end
            default: n_state = sha512_pkg::S_IDLE;
        endcase
    end

    // Handshake outputs, unit controls and the result beat.
    always_comb begin
        o_in_stall         = (r_state != sha512_pkg::S_IDLE);
        o_out_valid        = (r_state == sha512_pkg::S_OUT) || (r_state == sha512_pkg::S_ERR);
        sched_ctl.word_en  = (r_state == sha512_pkg::S_IDLE) && i_in_valid;
        sched_ctl.round_en = (r_state == sha512_pkg::S_COMP);
        round_ctl.init     = (r_state == sha512_pkg::S_IDLE) && i_in_valid && chunk_done;
        round_ctl.step     = (r_state == sha512_pkg::S_COMP);
        round_ctl.idx      = r_rnd;
        if (r_state == sha512_pkg::S_ERR) begin
            o_out_data.digest_word  = '0;
            o_out_data.final_word   = 1'b1;
            o_out_data.length_error = 1'b1;
        end else begin
            o_out_data.digest_word  = r_hash[r_oidx];
            o_out_data.final_word   = (r_oidx == sha512_pkg::LAST_DIGEST);
            o_out_data.length_error = 1'b0;
        end
    end

    // Counters and the chaining hash. The hash returns to the initial values on a
    // start flag, on a ragged end, and once the last digest beat has gone out.
    always_comb begin
        n_cnt  = r_cnt;
        n_rnd  = r_rnd;
        n_oidx = r_oidx;
        n_last = r_last;
        n_hash = r_hash;
        case (r_state)
            sha512_pkg::S_IDLE: begin
                n_rnd = '0;
                if (in_acc) begin
                    n_last = i_in_data.last_word;
                    n_cnt  = i_in_data.last_word ? '0 : eff_cnt + 1'b1;
                    if (i_in_data.start_message
                        || (i_in_data.last_word && !chunk_done)) begin
                        n_hash = sha512_pkg::INIT_HASH;
                    end
                end
            end
            sha512_pkg::S_COMP: begin
                n_rnd = r_rnd + 1'b1;
            end
            sha512_pkg::S_ADD: begin
                for (int i = 0; i < sha512_pkg::HASH_WORDS; i++) begin
                    n_hash[i] = r_hash[i] + vars[i];
                end
            end
            sha512_pkg::S_OUT: begin
                if (out_acc) begin
                    n_oidx = r_oidx + 1'b1;
                    if (r_oidx == sha512_pkg::LAST_DIGEST) begin
                        n_hash = sha512_pkg::INIT_HASH;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha512_pkg::S_IDLE;
            r_cnt   <= '0;
            r_rnd   <= '0;
            r_oidx  <= '0;
            r_last  <= 1'b0;
            r_hash  <= sha512_pkg::INIT_HASH;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
            r_last  <= n_last;
            r_hash  <= n_hash;
        end
    end

    sha512_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .i_word (i_in_data.message_word),
        .o_w    (sched_w)
    );

    sha512_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (round_ctl),
        .i_hash  (r_hash),
        .i_w     (sched_w),
        .o_vars  (vars)
    );

endmodule

FILE: design/sha512_sched.sv
// Message schedule for the SHA-512 hash core: a 16-word shift line.
// Depends on sha512_pkg for word types and the small sigma functions.
module sha512_sched (
    input  logic                   i_clk,
    input  sha512_pkg::t_sched_ctl i_ctl,
    input  sha512_pkg::t_word      i_word,
    output sha512_pkg::t_word      o_w
);

    // r_w[0] holds the oldest word, which is W[t] of the running round.
    sha512_pkg::t_word r_w [sha512_pkg::CHUNK_WORDS];
    sha512_pkg::t_word n_new;

    always_comb begin
        n_new = r_w[0] + sha512_pkg::small_sigma0(r_w[1]) + r_w[9]
              + sha512_pkg::small_sigma1(r_w[14]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.word_en || i_ctl.round_en) begin
            for (int i = 0; i < sha512_pkg::CHUNK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[sha512_pkg::CHUNK_WORDS-1] <= i_ctl.word_en ? i_word : n_new;
        end
    end

    assign o_w = r_w[0];

endmodule

FILE: design/sha512_round.sv
// One SHA-512 compression round, reused for all 80 rounds, with the a..h registers.
// Depends on sha512_pkg for types, round constants and the big sigma functions.
module sha512_round (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sha512_pkg::t_round_ctl i_ctl,
    input  sha512_pkg::t_hash      i_hash,
    input  sha512_pkg::t_word      i_w,
    output sha512_pkg::t_hash      o_vars
);

    sha512_pkg::t_hash r_v;
    sha512_pkg::t_hash n_v;
    sha512_pkg::t_word t1;
    sha512_pkg::t_word t2;
    sha512_pkg::t_word choose;
    sha512_pkg::t_word major;

    always_comb begin
        choose = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        major  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + sha512_pkg::big_sigma1(r_v[4]) + choose
           + sha512_pkg::round_k(i_ctl.idx) + i_w;
        t2 = sha512_pkg::big_sigma0(r_v[0]) + major;
        n_v[7] = r_v[6];
        n_v[6] = r_v[5];
        n_v[5] = r_v[4];
        n_v[4] = r_v[3] + t1;
        n_v[3] = r_v[2];
        n_v[2] = r_v[1];
        n_v[1] = r_v[0];
        n_v[0] = t1 + t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.init) begin
            r_v <= i_hash;
        end else if (i_ctl.step) begin
            r_v <= n_v;
        end
    end

    assign o_vars = r_v;

endmodule

FILE: design/sha512_chk.sv
// Port-level checker for the SHA-512 hash core and its bind to the top level.
// Depends on sha512_pkg for the payload types.
module sha512_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input sha512_pkg::t_in  i_in_data,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input sha512_pkg::t_out o_out_data
);

    // Input is never taken while a result beat is pending.
    a_stall_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input not stalled while a result is pending");

    // The closing beat of a message ends the result burst.
    a_burst_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.final_word) |=> !o_out_valid)
        else $error("result beat follows the closing beat");

    // An error beat is a lone closing beat with a zero digest word.
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.length_error)
            |-> (o_out_data.final_word && o_out_data.digest_word == '0))
        else $error("malformed error beat");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result beat changed");

endmodule

bind sha512_hash_core sha512_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
